// ===== rtl/drs_pkg.sv =====
package drs_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int TRK_W            = 16;
    localparam int MODE_W           = 2;

    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WRAP = 2'd3;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_HEAD = 1'b1;

    typedef struct packed {
        logic load;
        logic run_head;
        logic scan_start;
        logic emit_best;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic more;
    } t_dp_sts;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EMIT = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

endpackage

// ===== rtl/drs_ctrl.sv =====
module drs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_command,
    input  logic            i_m_tready,
    input  drs_pkg::t_dp_sts i_sts,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    output drs_pkg::t_dp_cmd o_cmd
);
    import drs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_command == CMD_RUN) begin
                        o_cmd.run_head = 1'b1;
                        n_state        = ST_EMIT;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_m_tready) begin
                    if (i_sts.more) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.emit_best = 1'b1;
                n_state         = ST_EMIT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_EMIT);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_m_tready) |=> (r_state == ST_EMIT))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid || r_state == ST_SCAN) |-> !o_s_tready)
        else $error("input accepted while busy");
    a_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_state == ST_EMIT))
        else $error("best not emitted");

endmodule

// ===== rtl/drs_datapath.sv =====
module drs_datapath #(
    parameter int MAX_REQUESTS = drs_pkg::MAX_REQUESTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  drs_pkg::t_dp_cmd           i_cmd,
    input  logic [drs_pkg::TRK_W-1:0]  i_track,
    input  logic [drs_pkg::MODE_W-1:0] i_mode,
    input  logic [drs_pkg::TRK_W-1:0]  i_head,
    output drs_pkg::t_dp_sts           o_sts,
    output logic [drs_pkg::TRK_W-1:0]  o_served_track,
    output logic                       o_is_last,
    output logic                       o_overflowed
);
    import drs_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    logic [TRK_W-1:0]        mem [MAX_REQUESTS];
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_done;
    logic                    r_ovf;
    logic [MAX_REQUESTS-1:0] r_mask;
    logic [AW-1:0]           r_addr;
    logic                    r_issue;
    logic                    r_vld;
    logic                    r_rlast;
    logic [AW-1:0]           r_ridx;
    logic [TRK_W-1:0]        r_rdata;
    logic                    r_found;
    logic [TRK_W:0]          r_best_key;
    logic [AW-1:0]           r_best_idx;
    logic [TRK_W-1:0]        r_best_trk;
    logic [TRK_W-1:0]        r_cur;
    logic [TRK_W-1:0]        r_out_trk;
    logic                    r_out_last;
    logic                    r_out_ovf;

    logic [TRK_W:0]   key;
    logic [TRK_W-1:0] seek_gap;
    logic             below;
    logic             issue_last;
    logic             take;

    assign below      = (r_rdata < i_head);
    assign seek_gap   = (r_cur > r_rdata) ? (r_cur - r_rdata) : (r_rdata - r_cur);
    assign issue_last = (r_addr == AW'(r_cnt - CW'(1)));
    assign take       = r_vld && !r_mask[r_ridx] && (!r_found || key < r_best_key);

    always_comb begin
        unique case (i_mode)
            MODE_FCFS: key = '0;
            MODE_SSTF: key = {1'b0, seek_gap};
            MODE_DOWN: key = below ? {1'b0, ~r_rdata} : {1'b1, r_rdata};
            MODE_WRAP: key = below ? {1'b1, r_rdata} : {1'b0, r_rdata};
            default:   key = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CW'(MAX_REQUESTS)) begin
            mem[AW'(r_cnt)] <= i_track;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_done  <= '0;
            r_ovf   <= 1'b0;
            r_mask  <= '0;
            r_issue <= 1'b0;
            r_vld   <= 1'b0;
            r_rlast <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_vld   <= r_issue;
            r_rlast <= r_issue && issue_last;
            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_REQUESTS)) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.run_head) begin
                r_done <= '0;
            end
            if (i_cmd.scan_start) begin
                r_issue <= 1'b1;
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (r_issue) begin
                if (issue_last) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + AW'(1);
                end
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit_best) begin
                r_mask[r_best_idx] <= 1'b1;
                r_done             <= r_done + CW'(1);
            end
            if (i_cmd.finish) begin
                r_cnt  <= '0;
                r_done <= '0;
                r_ovf  <= 1'b0;
                r_mask <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= r_addr;
        if (take) begin
            r_best_key <= key;
            r_best_idx <= r_ridx;
            r_best_trk <= r_rdata;
        end
        if (i_cmd.run_head) begin
            r_cur      <= i_head;
            r_out_trk  <= i_head;
            r_out_last <= (r_cnt == '0);
            r_out_ovf  <= r_ovf;
        end
        if (i_cmd.emit_best) begin
            r_cur      <= r_best_trk;
            r_out_trk  <= r_best_trk;
            r_out_last <= (r_done + CW'(1) == r_cnt);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_sts.scan_done = r_rlast;
    assign o_sts.more      = (r_done != r_cnt);
    assign o_served_track  = r_out_trk;
    assign o_is_last       = r_out_last;
    assign o_overflowed    = r_out_ovf;

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> (r_cnt != '0))
        else $error("scan over empty store");
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_cnt)
        else $error("emitted more than stored");
    a_best_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_best |-> r_found)
        else $error("emit without a candidate");

endmodule

// ===== rtl/disk_request_scheduler_top.sv =====
// Disk request scheduler.
// Slave stream: tuser carries the command (0 add, 1 run), tdata the track.
// An add transaction stores one track request; once the store holds
// MAX_REQUESTS entries further adds are dropped and flagged.
// A run transaction emits the service order on the master stream: first the
// head position, then every stored request once. tdata is the track, tlast
// marks the final track, tuser reports dropped requests since the last run.
// Order follows policy_mode (APB register 0 at address 0): first-come,
// shortest seek, down-then-up sweep, up-then-wrap sweep. head_position is
// APB register 1 at address 4.
// Each track after the head is chosen by a scan of the store through its
// single read port, which reads every stored request once per track.
// No input is taken while a run is being emitted. A stalled receiver holds
// the current result and pauses the run. Reset empties the store, clears
// the overflow flag and sets both registers to zero.
module disk_request_scheduler_top #(
    parameter int MAX_REQUESTS = drs_pkg::MAX_REQUESTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] request_track
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] served_track
    output logic        m_tlast,
    output logic        m_tuser,   // [0] overflowed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drs_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [TRK_W-1:0]  r_head;
    logic              wr_en;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_head <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                CFG_MODE: r_mode <= pwdata[MODE_W-1:0];
                CFG_HEAD: r_head <= pwdata[TRK_W-1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                CFG_MODE: prdata = {{(32-MODE_W){1'b0}}, r_mode};
                CFG_HEAD: prdata = {{(32-TRK_W){1'b0}}, r_head};
                default:  prdata = '0;
            endcase
        end
    end

    drs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_command  (s_tuser),
        .i_m_tready (m_tready),
        .i_sts      (sts),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .o_cmd      (cmd)
    );

    drs_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_track        (s_tdata),
        .i_mode         (r_mode),
        .i_head         (r_head),
        .o_sts          (sts),
        .o_served_track (m_tdata),
        .o_is_last      (m_tlast),
        .o_overflowed   (m_tuser)
    );

endmodule
